// File: src/lms_pkg.sv
// Shared types and constants for the 3x3 local-maximum suppression block.
// Depends on nothing; the sequencer, window and top files refer to it by scoped names.
package lms_pkg;

    // configuration register layout
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    // row geometry
    localparam int ROW_BITS = 12;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd3;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

    // request function codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // per-request control decided at acceptance, held in the request stage and used as it moves on
    typedef struct packed {
        logic pixel;        // pixel request (else flush)
        logic emit_border;  // first column: emit last column from two rows back
        logic emit_center;  // emit window center
        logic suppress;     // center is interior, apply the 3x3 test
        logic flush_emit;   // flush with something pending
        logic flush_upper;  // flush value comes from the upper store
        logic frame_last;   // final pixel of the frame
    } lms_ctrl_t;

endpackage

// File: src/lms_pixel_if.sv
// Input channel: valid/ready handshake carrying one pixel or flush request.
// Depends on nothing.
interface lms_pixel_if #(
    parameter int MAG_BITS = 11
);
    logic                valid;
    logic                ready;
    logic                func;
    logic [MAG_BITS-1:0] magnitude;

    modport source (output valid, func, magnitude, input ready);
    modport sink   (input valid, func, magnitude, output ready);
endinterface

// File: src/lms_result_if.sv
// Output channel: valid/ready handshake carrying one suppressed pixel.
// Depends on nothing.
interface lms_result_if #(
    parameter int MAG_BITS = 11
);
    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] suppressed_value;
    logic                frame_last;

    modport source (output valid, suppressed_value, frame_last, input ready);
    modport sink   (input valid, suppressed_value, frame_last, output ready);
endinterface

// File: src/lms_line_store.sv
// One row of pixel storage: single write port, single registered read port.
// A read at the address being written in the same cycle returns the new data.
module lms_line_store #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 11,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lms_sequencer.sv
// Configuration registers, raster counters, pending-pixel count and the
// request stage register. Uses lms_pkg for codes and the control struct.
module lms_sequencer #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_BITS  = 11,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int PEND_BITS = $clog2(MAX_WIDTH + 2)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               accept,
    input  logic                               func,
    input  logic [MAG_BITS-1:0]                magnitude,
    input  logic                               advance,
    output logic [COL_BITS-1:0]                rd_col_addr,
    output logic [COL_BITS-1:0]                rd_last_addr,
    output logic [COL_BITS-1:0]                rd_mid_addr,
    output logic                               stage_valid,
    output lms_pkg::lms_ctrl_t                 stage_ctrl,
    output logic [MAG_BITS-1:0]                stage_pix,
    output logic [COL_BITS-1:0]                stage_col
);

    logic [lms_pkg::CFG_WIDTH_BITS-1:0]  frame_width_reg;
    logic [lms_pkg::CFG_HEIGHT_BITS-1:0] frame_height_reg;

    logic [COL_BITS-1:0]          col_count_reg, col_count_next;
    logic [lms_pkg::ROW_BITS-1:0] row_count_reg, row_count_next;
    logic [PEND_BITS-1:0]         pending_reg, pending_next;

    logic                 stage_valid_reg, stage_valid_next;
    lms_pkg::lms_ctrl_t   stage_ctrl_reg, stage_ctrl_next;
    logic [MAG_BITS-1:0]  stage_pix_reg;
    logic [COL_BITS-1:0]  stage_col_reg;

    logic [PEND_BITS-1:0]                w_used, w_plus1, pend_used;
    logic [lms_pkg::CFG_HEIGHT_BITS-1:0] h_used;
    logic [COL_BITS-1:0]                 col_used;
    logic [lms_pkg::ROW_BITS-1:0]        row_used;
    logic                                last_col, last_row, is_flush;

    // clamp geometry and counters
    always_comb
    begin
        priority if (32'(frame_width_reg) < 32'd3)
            w_used = PEND_BITS'(3);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_used = PEND_BITS'(MAX_WIDTH);
        else
            w_used = PEND_BITS'(frame_width_reg);

        priority if (frame_height_reg < lms_pkg::HEIGHT_MIN)
            h_used = lms_pkg::HEIGHT_MIN;
        else if (frame_height_reg > lms_pkg::HEIGHT_LIMIT)
            h_used = lms_pkg::HEIGHT_LIMIT;
        else
            h_used = frame_height_reg;

        w_plus1 = w_used + PEND_BITS'(1);

        if (PEND_BITS'(col_count_reg) >= w_used)
            col_used = COL_BITS'(w_used - PEND_BITS'(1));
        else
            col_used = col_count_reg;

        if ({1'b0, row_count_reg} >= h_used)
            row_used = lms_pkg::ROW_BITS'(h_used - 13'd1);
        else
            row_used = row_count_reg;

        last_col  = (PEND_BITS'(col_used) + PEND_BITS'(1)) >= w_used;
        last_row  = ({1'b0, row_used} + 13'd1) >= h_used;
        pend_used = (pending_reg > w_plus1) ? w_plus1 : pending_reg;
        is_flush  = (func == lms_pkg::FUNC_FLUSH);
    end

    // per-request control and next state
    always_comb
    begin
        stage_ctrl_next.pixel       = !is_flush;
        stage_ctrl_next.emit_border = !is_flush && (col_used == '0)
                                      && (row_used >= 12'd2);
        stage_ctrl_next.emit_center = !is_flush && (col_used != '0)
                                      && (row_used != '0);
        stage_ctrl_next.suppress    = (row_used >= 12'd2) && (col_used >= COL_BITS'(2));
        stage_ctrl_next.flush_emit  = is_flush && (pend_used != '0);
        stage_ctrl_next.flush_upper = (pend_used == w_plus1);
        stage_ctrl_next.frame_last  = (pend_used == PEND_BITS'(1));

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        pending_next   = pending_reg;
        if (accept)
        begin
            if (is_flush)
            begin
                if (pend_used != '0)
                    pending_next = pend_used - PEND_BITS'(1);
            end
            else
            begin
                pending_next = '0;
                if (last_col)
                begin
                    col_count_next = '0;
                    if (last_row)
                    begin
                        row_count_next = '0;
                        pending_next   = w_plus1;
                    end
                    else
                    begin
                        row_count_next = row_used + 12'd1;
                    end
                end
                else
                begin
                    col_count_next = col_used + COL_BITS'(1);
                    row_count_next = row_used;
                end
            end
        end

        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lms_pkg::WIDTH_RESET;
            frame_height_reg <= lms_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lms_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[lms_pkg::CFG_WIDTH_BITS-1:0];
                lms_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[lms_pkg::CFG_HEIGHT_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            pending_reg     <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            col_count_reg   <= col_count_next;
            row_count_reg   <= row_count_next;
            pending_reg     <= pending_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_ctrl_reg <= stage_ctrl_next;
            stage_pix_reg  <= magnitude;
            stage_col_reg  <= col_used;
        end
    end

    assign rd_col_addr  = col_used;
    assign rd_last_addr = COL_BITS'(w_used - PEND_BITS'(1));
    assign rd_mid_addr  = is_flush ? COL_BITS'(w_used - pend_used) : col_used;

    assign stage_valid = stage_valid_reg;
    assign stage_ctrl  = stage_ctrl_reg;
    assign stage_pix   = stage_pix_reg;
    assign stage_col   = stage_col_reg;

endmodule

// File: src/lms_window.sv
// 3x3 window columns, the local-maximum test and result selection.
// Uses lms_pkg for the stage control struct.
module lms_window #(
    parameter int MAG_BITS = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  lms_pkg::lms_ctrl_t  ctrl,
    input  logic [MAG_BITS-1:0] pix,
    input  logic [MAG_BITS-1:0] up_rd,
    input  logic [MAG_BITS-1:0] mid_rd,
    input  logic [MAG_BITS-1:0] up_last_rd,
    output logic                emit,
    output logic [MAG_BITS-1:0] value,
    output logic                last
);

    // column 1 and column 2 of the window; column 0 is never needed after a shift
    logic [MAG_BITS-1:0] col1_reg [3];
    logic [MAG_BITS-1:0] col2_reg [3];

    logic [MAG_BITS-1:0] center, center_val;
    logic                beaten;

    always_comb
    begin
        center = col2_reg[1];
        beaten = (center < up_rd) || (center < mid_rd) || (center < pix)
                 || (center < col2_reg[0]) || (center < col2_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            beaten = beaten || (center < col1_reg[i]);
        end
        center_val = (ctrl.suppress && beaten) ? '0 : center;
    end

    always_comb
    begin
        emit  = 1'b0;
        value = '0;
        last  = 1'b0;
        priority if (!ctrl.pixel)
        begin
            emit  = ctrl.flush_emit;
            value = ctrl.flush_upper ? up_last_rd : mid_rd;
            last  = ctrl.frame_last;
        end
        else if (ctrl.emit_border)
        begin
            emit  = 1'b1;
            value = up_last_rd;
        end
        else if (ctrl.emit_center)
        begin
            emit  = 1'b1;
            value = center_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                col1_reg[i] <= '0;
                col2_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                col1_reg[i] <= col2_reg[i];
            end
            col2_reg[0] <= up_rd;
            col2_reg[1] <= mid_rd;
            col2_reg[2] <= pix;
        end
    end

endmodule

// File: src/local_max_suppression_3x3_top.sv
// A staged request enters the output register when its stage advances. Throughput: one
// request per cycle while the consumer keeps up, set by the single request stage and the
// registered line-store read ports; a pixel leaves frame_width+1 requests after arrival.
// Reset (rst_n, async, low): counters, pending count, window and valid flags clear; geometry
// returns to 640x480; the line stores are not cleared and are rewritten by the first rows.
module local_max_suppression_3x3_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_BITS  = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lms_pixel_if.sink                          pixel,
    lms_result_if.source                       result
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    logic                accept, advance, store_we;
    logic [COL_BITS-1:0] rd_col_addr, rd_last_addr, rd_mid_addr, stage_col;
    logic                stage_valid;
    lms_pkg::lms_ctrl_t  stage_ctrl;
    logic [MAG_BITS-1:0] stage_pix;
    logic [MAG_BITS-1:0] up_rd, up_last_rd, mid_rd;
    logic                win_emit, win_last;
    logic [MAG_BITS-1:0] win_value;

    logic                out_valid_reg, out_valid_next;
    logic [MAG_BITS-1:0] out_value_reg;
    logic                out_last_reg;

    // The request stage moves on whenever the output register is empty or being drained,
    // so a new request is taken every cycle unless the consumer holds off.
    assign advance     = !out_valid_reg || result.ready;
    assign pixel.ready = !stage_valid || advance;
    assign accept      = pixel.valid && pixel.ready;

    // Line stores are written as the staged pixel request moves on; the read for a request
    // issued at the same edge sees that write through the store's bypass.
    assign store_we = stage_valid && advance && stage_ctrl.pixel;

    lms_sequencer #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS)
    ) u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .func         (pixel.func),
        .magnitude    (pixel.magnitude),
        .advance      (advance),
        .rd_col_addr  (rd_col_addr),
        .rd_last_addr (rd_last_addr),
        .rd_mid_addr  (rd_mid_addr),
        .stage_valid  (stage_valid),
        .stage_ctrl   (stage_ctrl),
        .stage_pix    (stage_pix),
        .stage_col    (stage_col)
    );

    // Upper row store, read at the current column.
    lms_line_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (MAG_BITS)
    ) u_upper (
        .clk   (clk),
        .we    (store_we),
        .waddr (stage_col),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (rd_col_addr),
        .rdata (up_rd)
    );

    // Copy of the upper store, read at the last column: the border pixel at a row start
    // and the first flushed pixel come from there.
    lms_line_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (MAG_BITS)
    ) u_upper_last (
        .clk   (clk),
        .we    (store_we),
        .waddr (stage_col),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (rd_last_addr),
        .rdata (up_last_rd)
    );

    // Middle row store: current column for pixels, drain position for flushes.
    lms_line_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (MAG_BITS)
    ) u_middle (
        .clk   (clk),
        .we    (store_we),
        .waddr (stage_col),
        .wdata (stage_pix),
        .re    (accept),
        .raddr (rd_mid_addr),
        .rdata (mid_rd)
    );

    lms_window #(
        .MAG_BITS (MAG_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (store_we),
        .ctrl       (stage_ctrl),
        .pix        (stage_pix),
        .up_rd      (up_rd),
        .mid_rd     (mid_rd),
        .up_last_rd (up_last_rd),
        .emit       (win_emit),
        .value      (win_value),
        .last       (win_last)
    );

    // Output register: a request that causes no result simply leaves it empty.
    assign out_valid_next = advance ? (stage_valid && win_emit) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= win_value;
            out_last_reg  <= win_last;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.suppressed_value = out_value_reg;
    assign result.frame_last       = out_last_reg;

endmodule

// File: src/lms_port_checker.sv
// Port-level checks for the suppression block, attached by the bind below.
// Depends on local_max_suppression_3x3_top and its channel interfaces.
module lms_port_checker #(
    parameter int MAG_BITS = 11
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [MAG_BITS-1:0] out_value,
    input logic                out_last
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
        else $error("result payload changed while stalled");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty output");

    // a fresh result always follows an earlier request that passed through the request stage
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a recent request");

endmodule

bind local_max_suppression_3x3_top lms_port_checker #(
    .MAG_BITS (MAG_BITS)
) u_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.suppressed_value),
    .out_last  (result.frame_last)
);
